// ----- rtl/qrp_pkg.sv -----
// ----------------------------------------------------------------------------
// qrp_pkg
// Shared types, constants and arcsine tables for the quaternion to
// roll/pitch converter.
// ----------------------------------------------------------------------------
package qrp_pkg;

  // field widths
  localparam int unsigned QuatW  = 16;
  localparam int unsigned AngleW = 15;
  localparam int unsigned ProdW  = 2 * QuatW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned IdxW   = 7;
  localparam int unsigned NibW   = 4;

  // decoupling queue depth between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // arcsine saturation angle (argument magnitude of one or more)
  localparam logic [AngleW-1:0] AngleSat = 15'h3FFF;

  // classified arcsine argument for one angle
  typedef struct packed {
    logic            neg;
    logic            sat;
    logic [IdxW-1:0] idx;
    logic [NibW-1:0] nib;
  } asin_arg_t;

  // one queue entry: both angles of one request
  typedef struct packed {
    asin_arg_t roll;
    asin_arg_t pitch;
  } arg_pair_t;

  // arcsine base table, bits 10..4 of the argument magnitude select the entry
  localparam logic [15:0] AsinBase [128] = '{
    16'h0000, 16'h0051, 16'h00A3, 16'h00F4, 16'h0146, 16'h0198, 16'h01E9, 16'h023B,
    16'h028C, 16'h02DE, 16'h0330, 16'h0381, 16'h03D3, 16'h0425, 16'h0477, 16'h04C9,
    16'h051B, 16'h056D, 16'h05C0, 16'h0612, 16'h0664, 16'h06B7, 16'h070A, 16'h075C,
    16'h07AF, 16'h0802, 16'h0855, 16'h08A9, 16'h08FC, 16'h0950, 16'h09A3, 16'h09F7,
    16'h0A4B, 16'h0AA0, 16'h0AF4, 16'h0B49, 16'h0B9E, 16'h0BF3, 16'h0C48, 16'h0C9D,
    16'h0CF3, 16'h0D49, 16'h0D9F, 16'h0DF5, 16'h0E4C, 16'h0EA3, 16'h0EFA, 16'h0F52,
    16'h0FA9, 16'h1001, 16'h105A, 16'h10B2, 16'h110B, 16'h1165, 16'h11BE, 16'h1218,
    16'h1273, 16'h12CE, 16'h1329, 16'h1385, 16'h13E1, 16'h143D, 16'h149A, 16'h14F7,
    16'h1555, 16'h15B4, 16'h1612, 16'h1672, 16'h16D2, 16'h1732, 16'h1793, 16'h17F5,
    16'h1857, 16'h18BA, 16'h191D, 16'h1982, 16'h19E7, 16'h1A4C, 16'h1AB3, 16'h1B1A,
    16'h1B82, 16'h1BEA, 16'h1C54, 16'h1CBF, 16'h1D2A, 16'h1D97, 16'h1E04, 16'h1E73,
    16'h1EE2, 16'h1F53, 16'h1FC5, 16'h2038, 16'h20AD, 16'h2123, 16'h219A, 16'h2213,
    16'h228D, 16'h2309, 16'h2387, 16'h2407, 16'h2488, 16'h250C, 16'h2592, 16'h261A,
    16'h26A4, 16'h2731, 16'h27C1, 16'h2854, 16'h28EA, 16'h2984, 16'h2A21, 16'h2AC3,
    16'h2B69, 16'h2C13, 16'h2CC4, 16'h2D7A, 16'h2E37, 16'h2EFC, 16'h2FC9, 16'h30A1,
    16'h3184, 16'h3276, 16'h3379, 16'h3493, 16'h35C9, 16'h3729, 16'h38C9, 16'h3AE7
  };

  // arcsine slope table, scaled by the low nibble of the argument
  localparam logic [7:0] AsinStep [128] = '{
    8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
    8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
    8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
    8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
    8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
    8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05,
    8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
    8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
    8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
    8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
    8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07,
    8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h08, 8'h08,
    8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h09, 8'h09,
    8'h09, 8'h09, 8'h09, 8'h09, 8'h0A, 8'h0A, 8'h0A, 8'h0A,
    8'h0B, 8'h0B, 8'h0B, 8'h0C, 8'h0C, 8'h0D, 8'h0D, 8'h0E,
    8'h0F, 8'h10, 8'h12, 8'h13, 8'h16, 8'h1A, 8'h22, 8'h52
  };

endpackage

// ----- rtl/qrp_if.sv -----
// ----------------------------------------------------------------------------
// qrp_quat_if / qrp_angle_if
// Valid/ready channels carrying a quaternion request and its angle result.
// ----------------------------------------------------------------------------
interface qrp_quat_if;
  logic                                valid;
  logic                                ready;
  logic signed [qrp_pkg::QuatW-1:0]    quat_w;
  logic signed [qrp_pkg::QuatW-1:0]    quat_x;
  logic signed [qrp_pkg::QuatW-1:0]    quat_y;
  logic signed [qrp_pkg::QuatW-1:0]    quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y,
                  output quat_z, input ready);
  modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

interface qrp_angle_if;
  logic                                valid;
  logic                                ready;
  logic signed [qrp_pkg::AngleW-1:0]   roll_angle;
  logic signed [qrp_pkg::AngleW-1:0]   pitch_angle;

  modport source (output valid, output roll_angle, output pitch_angle, input ready);
  modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

// ----- rtl/quaternion_to_roll_pitch_top.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_roll_pitch_top
// Converts a Q2.14 unit quaternion into roll and pitch angles using a
// table-interpolated arcsine.
// ----------------------------------------------------------------------------
// Takes one quaternion request per clock while in_ready is high and returns one
// roll/pitch result per request, in order. Components are Q2.14 (0x4000 = 1) and should stay
// within +-0x4000; angles are 15-bit signed with 0x4000 = 90 degrees. The
// four 16x16 products are registered when a request is accepted, then the
// sums and argument classification are registered, then the pair passes
// through the queue, and then the arcsine table lookup with its 4x7 slope
// multiply goes into the output register. A four-entry queue between the
// classification stage and the arcsine stage lets the input keep flowing
// while the output is stalled, until the queue is full.
module quaternion_to_roll_pitch_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  qrp_quat_if.sink    quat_i,
  qrp_angle_if.source angle_o
);

  logic               fr_valid, fr_ready;
  qrp_pkg::arg_pair_t fr_pair;
  logic               bk_valid, bk_ready;
  qrp_pkg::arg_pair_t bk_pair;

  // front: products and classification
  qrp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (quat_i.valid),
    .in_ready_o  (quat_i.ready),
    .quat_w_i    (quat_i.quat_w),
    .quat_x_i    (quat_i.quat_x),
    .quat_y_i    (quat_i.quat_y),
    .quat_z_i    (quat_i.quat_z),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_pair_o  (fr_pair)
  );

  // decoupling queue
  qrp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_pair_i  (fr_pair),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_pair_o   (bk_pair)
  );

  // back: arcsine and output register
  qrp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (bk_valid),
    .in_ready_o    (bk_ready),
    .in_pair_i     (bk_pair),
    .out_valid_o   (angle_o.valid),
    .out_ready_i   (angle_o.ready),
    .roll_angle_o  (angle_o.roll_angle),
    .pitch_angle_o (angle_o.pitch_angle)
  );

endmodule

// ----- rtl/qrp_front.sv -----
// ----------------------------------------------------------------------------
// qrp_front
// Takes quaternion requests, forms the two sums of products and classifies
// each arcsine argument (sign, saturation, table index, nibble).
// ----------------------------------------------------------------------------
module qrp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [qrp_pkg::QuatW-1:0] quat_w_i,
  input  logic signed [qrp_pkg::QuatW-1:0] quat_x_i,
  input  logic signed [qrp_pkg::QuatW-1:0] quat_y_i,
  input  logic signed [qrp_pkg::QuatW-1:0] quat_z_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output qrp_pkg::arg_pair_t              out_pair_o
);

  logic                             mul_vld_q;
  logic signed [qrp_pkg::ProdW-1:0] p_yz_q, p_xw_q, p_yw_q, p_zx_q;
  logic                             cls_vld_q;
  qrp_pkg::arg_pair_t               cls_pair_q;

  logic                             cls_ready, mul_ready;
  logic signed [qrp_pkg::SumW-1:0]  roll_sum, pitch_sum;

  // stage handshakes
  assign cls_ready  = !cls_vld_q || out_ready_i;
  assign mul_ready  = !mul_vld_q || cls_ready;
  assign in_ready_o = mul_ready;

  // classify a shifted sum for the arcsine table
  function automatic qrp_pkg::asin_arg_t classify(logic signed [qrp_pkg::SumW-1:0] sum);
    logic [15:0]        arg;
    logic [15:0]        mag;
    qrp_pkg::asin_arg_t r;
    arg   = sum[31:16];
    mag   = arg[15] ? ~arg : arg;
    r.neg = arg[15];
    r.sat = (mag[15:11] != 5'd0);
    r.idx = mag[10:4];
    r.nib = mag[3:0];
    return r;
  endfunction

  // sums of products
  assign roll_sum  = qrp_pkg::SumW'(p_yz_q) + qrp_pkg::SumW'(p_xw_q);
  assign pitch_sum = qrp_pkg::SumW'(p_yw_q) - qrp_pkg::SumW'(p_zx_q);

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      cls_vld_q <= 1'b0;
    end else begin
      if (mul_ready) mul_vld_q <= in_valid_i;
      if (cls_ready) cls_vld_q <= mul_vld_q;
    end
  end

  // multiplier stage
  always_ff @(posedge clk_i) begin
    if (mul_ready && in_valid_i) begin
      p_yz_q <= quat_y_i * quat_z_i;
      p_xw_q <= quat_x_i * quat_w_i;
      p_yw_q <= quat_y_i * quat_w_i;
      p_zx_q <= quat_z_i * quat_x_i;
    end
  end

  // classification stage
  always_ff @(posedge clk_i) begin
    if (cls_ready && mul_vld_q) begin
      cls_pair_q.roll  <= classify(roll_sum);
      cls_pair_q.pitch <= classify(pitch_sum);
    end
  end

  assign out_valid_o = cls_vld_q;
  assign out_pair_o  = cls_pair_q;

endmodule

// ----- rtl/qrp_queue.sv -----
// ----------------------------------------------------------------------------
// qrp_queue
// Short queue of classified arguments between the front and the back.
// ----------------------------------------------------------------------------
module qrp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  qrp_pkg::arg_pair_t push_pair_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output qrp_pkg::arg_pair_t pop_pair_o
);

  qrp_pkg::arg_pair_t                 entry_q [qrp_pkg::QueueDepth];
  logic [qrp_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [qrp_pkg::QueueCntW-1:0]      count_q, count_d;
  logic                               push, pop;

  assign push_ready_o = (count_q != qrp_pkg::QueueCntW'(qrp_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_pair_o   = entry_q[rd_ptr_q];

  // occupancy
  always_comb begin
    count_d = count_q;
    if (push && !pop) count_d = count_q + 1'b1;
    else if (pop && !push) count_d = count_q - 1'b1;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_pair_i;
  end

  // occupancy never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= qrp_pkg::QueueCntW'(qrp_pkg::QueueDepth))
    else $error("queue count above depth");

  // pointer distance matches the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[qrp_pkg::QueuePtrW-1:0])
    else $error("queue pointers disagree with count");

  // count advances on a push without a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// ----- rtl/qrp_back.sv -----
// ----------------------------------------------------------------------------
// qrp_back
// Table arcsine for both angles and the output register.
// ----------------------------------------------------------------------------
module qrp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  qrp_pkg::arg_pair_t               in_pair_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [qrp_pkg::AngleW-1:0] roll_angle_o,
  output logic signed [qrp_pkg::AngleW-1:0] pitch_angle_o
);

  logic                         out_vld_q;
  logic [qrp_pkg::AngleW-1:0]   roll_q, pitch_q;
  logic                         take;

  // base plus slope times nibble, saturate, then restore the sign
  function automatic logic [qrp_pkg::AngleW-1:0] asin_angle(qrp_pkg::asin_arg_t a);
    logic [qrp_pkg::AngleW-1:0] base;
    logic [6:0]                 step;
    logic [10:0]                lerp;
    logic [qrp_pkg::AngleW-1:0] ang;
    base = qrp_pkg::AsinBase[a.idx][qrp_pkg::AngleW-1:0];
    step = qrp_pkg::AsinStep[a.idx][6:0];
    lerp = 11'(a.nib) * 11'(step);
    ang  = a.sat ? qrp_pkg::AngleSat : base + qrp_pkg::AngleW'(lerp);
    return a.neg ? ~ang : ang;
  endfunction

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      out_vld_q <= in_valid_i;
    end
  end

  // output angles
  always_ff @(posedge clk_i) begin
    if (take) begin
      roll_q  <= asin_angle(in_pair_i.roll);
      pitch_q <= asin_angle(in_pair_i.pitch);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign roll_angle_o  = $signed(roll_q);
  assign pitch_angle_o = $signed(pitch_q);

endmodule
